>>> rtl/core/ppc_pkg.sv
// Shared types and fixed constants of the profile peak cluster unit.
package ppc_pkg;

   localparam int DIST_BITS   = 12;
   localparam int POS_BITS    = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = 16'hFFFF;
   localparam logic [DIST_BITS-1:0] DIST_RESET = 12'd20;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic peak_valid;
      logic last_peak;
   } ppc_flags_type;

   localparam int FLAGS_BITS = $bits(ppc_flags_type);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } ppc_state_type;

endpackage

>>> rtl/core/ppc_queue.sv
// Four-entry job queue between the peak front end and the divider back end.
module ppc_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_a,
   input  logic [WIDTH-1:0] data_a,
   input  logic             push_b,
   input  logic [WIDTH-1:0] data_b,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             room_two
);

   logic [WIDTH-1:0] slot_ff [ppc_pkg::QUEUE_DEPTH];
   logic [ppc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ppc_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [ppc_pkg::QUEUE_PTR_BITS-1:0] wr_next;

   assign wr_next  = wr_ptr_ff + 1'b1;
   assign head     = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign room_two = (count_ff <= ppc_pkg::QUEUE_CNT_BITS'(ppc_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ppc_pkg::QUEUE_PTR_BITS'(push_a) + ppc_pkg::QUEUE_PTR_BITS'(push_b);
      rd_ptr_in = rd_ptr_ff + ppc_pkg::QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + ppc_pkg::QUEUE_CNT_BITS'(push_a)
                  + ppc_pkg::QUEUE_CNT_BITS'(push_b) - ppc_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         slot_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         slot_ff[wr_next] <= data_b;
      end
   end

endmodule

>>> rtl/core/ppc_front.sv
// Front end: sample differencing, peak detection and cluster bookkeeping.
module ppc_front #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 12,
   parameter int IDX_BITS    = 13,
   parameter int SUM_BITS    = 26,
   parameter int JOB_BITS    = 41
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [SAMPLE_BITS-1:0]         sample,
   input  logic                           last_sample,
   input  logic [ppc_pkg::DIST_BITS-1:0]  distance,
   output logic                           push_a,
   output logic [JOB_BITS-1:0]            job_a,
   output logic                           push_b,
   output logic [JOB_BITS-1:0]            job_b
);

   localparam int CMP_BITS = (IDX_BITS > ppc_pkg::DIST_BITS) ? IDX_BITS : ppc_pkg::DIST_BITS;

   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                   prev_ge0_ff, prev_ge0_in;
   logic                   open_ff, open_in;
   logic [IDX_BITS-1:0]    first_ff, first_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [IDX_BITS-1:0]    count_ff, count_in;

   logic                in_range, is_peak, merge, close_job;
   logic [IDX_BITS-1:0] peak;
   ppc_pkg::ppc_flags_type close_flags, last_flags;

   assign in_range = (idx_ff < IDX_BITS'(MAX_SAMPLES));
   assign peak     = idx_ff - 1'b1;
   assign is_peak  = in_range && (idx_ff >= IDX_BITS'(2)) && prev_ge0_ff && (sample <= prev_ff);
   assign merge    = open_ff
                     && (CMP_BITS'(peak - first_ff) < CMP_BITS'(distance));
   assign close_job = is_peak && !merge && open_ff;

   always_comb begin
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      prev_ge0_in = prev_ge0_ff;
      open_in     = open_ff;
      first_in    = first_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (in_range) begin
         if (idx_ff != '0) begin
            prev_ge0_in = (sample >= prev_ff);
         end
         prev_in = sample;
         idx_in  = idx_ff + 1'b1;
      end
      if (is_peak) begin
         if (merge) begin
            sum_in   = sum_ff + SUM_BITS'(peak);
            count_in = count_ff + 1'b1;
         end else begin
            open_in  = 1'b1;
            first_in = peak;
            sum_in   = SUM_BITS'(peak);
            count_in = IDX_BITS'(1);
         end
      end
   end

   always_comb begin
      close_flags.peak_valid = 1'b1;
      close_flags.last_peak  = 1'b0;
      last_flags.peak_valid  = open_in;
      last_flags.last_peak   = 1'b1;
      push_a = accept && (close_job || last_sample);
      push_b = accept && close_job && last_sample;
      if (close_job) begin
         job_a = {close_flags, count_ff, sum_ff};
      end else begin
         job_a = {last_flags, count_in, sum_in};
      end
      job_b = {last_flags, count_in, sum_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         prev_ge0_ff <= 1'b1;
         open_ff     <= 1'b0;
      end else if (accept) begin
         // reset the index, slope flag and open-cluster flag once the last sample is flushed
         if (last_sample) begin
            idx_ff      <= '0;
            prev_ge0_ff <= 1'b1;
            open_ff     <= 1'b0;
         end else begin
            idx_ff      <= idx_in;
            prev_ge0_ff <= prev_ge0_in;
            open_ff     <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff  <= prev_in;
         first_ff <= first_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/ppc_back.sv
// Back end: restoring divider for the cluster mean and the result register.
module ppc_back #(
   parameter int IDX_BITS      = 13,
   parameter int SUM_BITS      = 26,
   parameter int FRACTION_BITS = 4,
   parameter int JOB_BITS      = 41
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [JOB_BITS-1:0]           job,
   input  logic                          job_empty,
   output logic                          job_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [ppc_pkg::POS_BITS-1:0]  rsp_peak_position,
   output logic                          rsp_peak_valid,
   output logic                          rsp_last_peak
);

   localparam int DW = SUM_BITS + FRACTION_BITS;
   localparam int RW = IDX_BITS + 1;
   localparam int SW = $clog2(DW + 1);
   localparam int QW = (DW > ppc_pkg::POS_BITS) ? DW : ppc_pkg::POS_BITS;

   ppc_pkg::ppc_state_type state_ff, state_in;
   ppc_pkg::ppc_flags_type flags_ff, flags_in, job_flags;
   logic [IDX_BITS-1:0] job_count, div_ff, div_in;
   logic [SUM_BITS-1:0] job_sum;
   logic [DW-1:0]       quot_ff, quot_in;
   logic [RW-1:0]       rem_ff, rem_in, shifted;
   logic [RW:0]         trial;
   logic [SW-1:0]       step_ff, step_in;
   logic                out_valid_ff, out_valid_in, out_load;
   logic [ppc_pkg::POS_BITS-1:0] out_pos_ff, mean;
   ppc_pkg::ppc_flags_type out_flags_ff;

   assign {job_flags, job_count, job_sum} = job;

   assign shifted = {rem_ff[RW-2:0], quot_ff[DW-1]};
   assign trial   = {1'b0, shifted} - (RW + 1)'(div_ff);
   assign mean    = (QW'(quot_ff) > QW'(ppc_pkg::POS_MAX)) ? ppc_pkg::POS_MAX
                    : ppc_pkg::POS_BITS'(quot_ff);
   assign out_load = (state_ff == ppc_pkg::ST_DONE) && (!out_valid_ff || rsp_pop);
   assign job_pop  = (state_ff == ppc_pkg::ST_IDLE) && !job_empty;

   always_comb begin
      state_in = state_ff;
      flags_in = flags_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (!job_empty) begin
               flags_in = job_flags;
               div_in   = job_count;
               quot_in  = {job_sum, FRACTION_BITS'(0)};
               rem_in   = '0;
               step_in  = SW'(DW);
               if (job_flags.peak_valid) begin
                  state_in = ppc_pkg::ST_DIV;
               end else begin
                  quot_in  = '0;
                  state_in = ppc_pkg::ST_DONE;
               end
            end
         end
         ppc_pkg::ST_DIV: begin
            // one quotient bit per cycle
            quot_in = {quot_ff[DW-2:0], !trial[RW]};
            rem_in  = trial[RW] ? shifted : trial[RW-1:0];
            step_in = step_ff - 1'b1;
            if (step_ff == SW'(1)) begin
               state_in = ppc_pkg::ST_DONE;
            end
         end
         ppc_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = ppc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      div_ff   <= div_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      if (out_load) begin
         out_pos_ff   <= mean;
         out_flags_ff <= flags_ff;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_peak_position = out_pos_ff;
   assign rsp_peak_valid    = out_flags_ff.peak_valid;
   assign rsp_last_peak     = out_flags_ff.last_peak;

endmodule

>>> rtl/core/profile_peak_cluster_unit.sv
// Top level of the profile peak cluster unit: front end, job queue, divider back end.
//
//   channel  direction  transfer when          payload
//   req_     in         req_push & !req_full   req_sample, req_last_sample
//   rsp_     out        rsp_pop & !rsp_empty   rsp_peak_position, rsp_peak_valid, rsp_last_peak
//   csr_     in         csr_valid & csr_ready  csr_data (cluster distance)
//
// The front end takes one sample per cycle as long as the job queue has room for two jobs.
// Each closed cluster passes the back end's divider for SUM_BITS + FRACTION_BITS quotient bits
// (30 at the default sizes) before the hand-off; a profile end with no cluster skips the divider.
// The four-entry job queue absorbs bursts; req_full stalls input when fewer than two are free.
// rsp_empty low presents a held result; a stalled rsp_pop holds it while the divider runs on.
// Reset is synchronous and clears the profile, the queue and sets the distance to 20.
module profile_peak_cluster_unit #(
   parameter int MAX_SAMPLES   = 4096,
   parameter int SAMPLE_BITS   = 12,
   parameter int FRACTION_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   input  logic                          req_last_sample,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ppc_pkg::POS_BITS-1:0]  rsp_peak_position,
   output logic                          rsp_peak_valid,
   output logic                          rsp_last_peak,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppc_pkg::DIST_BITS-1:0] csr_data
);

   // index must hold MAX_SAMPLES itself; sum of peaks is below MAX_SAMPLES squared
   localparam int IDX_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS = 2 * IDX_BITS;
   localparam int JOB_BITS = ppc_pkg::FLAGS_BITS + IDX_BITS + SUM_BITS;

   logic [ppc_pkg::DIST_BITS-1:0] distance_ff, distance_in;
   logic                req_accept;
   logic                push_a, push_b, job_pop, job_empty, room_two;
   logic [JOB_BITS-1:0] job_a, job_b, job_head;

   // the distance register takes a write every cycle it is offered
   assign csr_ready   = 1'b1;
   assign distance_in = (csr_valid && csr_ready) ? csr_data : distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff <= ppc_pkg::DIST_RESET;
      end else begin
         distance_ff <= distance_in;
      end
   end

   // hold input while the queue cannot take a close job and a flush job together
   assign req_full   = !room_two;
   assign req_accept = req_push && !req_full;

   ppc_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_BITS    (IDX_BITS),
      .SUM_BITS    (SUM_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample      (req_sample),
      .last_sample (req_last_sample),
      .distance    (distance_ff),
      .push_a      (push_a),
      .job_a       (job_a),
      .push_b      (push_b),
      .job_b       (job_b)
   );

   ppc_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_a   (push_a),
      .data_a   (job_a),
      .push_b   (push_b),
      .data_b   (job_b),
      .pop      (job_pop),
      .head     (job_head),
      .empty    (job_empty),
      .room_two (room_two)
   );

   ppc_back #(
      .IDX_BITS      (IDX_BITS),
      .SUM_BITS      (SUM_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .JOB_BITS      (JOB_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (job_head),
      .job_empty         (job_empty),
      .job_pop           (job_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_peak_position (rsp_peak_position),
      .rsp_peak_valid    (rsp_peak_valid),
      .rsp_last_peak     (rsp_last_peak)
   );

endmodule

>>> sim/profile_peak_cluster_unit_test.sv
// Self-checking testbench for the profile peak cluster unit: directed table, then random profiles.
module profile_peak_cluster_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SAMPLES   = 4096;
   localparam int SAMPLE_BITS   = 12;
   localparam int FRACTION_BITS = 4;
   localparam int SUM_BITS      = 24;
   localparam int INDEX_BITS    = 13;
   // Idle time before touching the CSR, enough for the divider to finish a closed cluster.
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 600;
   localparam int RANDOM_PHASES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int KEEP          = -1;

   typedef enum int {GAP_NONE, GAP_SOME, GAP_FULL} gap_mode_type;
   typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_PLATEAU, SHAPE_ZIGZAG} shape_type;

   typedef struct packed {
      logic [ppc_pkg::POS_BITS-1:0] position;
      logic                         valid;
      logic                         last;
   } peak_report_type;

   localparam peak_report_type NO_REPORT = '0;

   // One directed transfer: an optional distance write before it, the sample, and,
   // where typed is set, the single result the sample must produce.
   typedef struct {
      int                     set_distance;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
      logic                   typed;
      peak_report_type        want;
   } stim_row_type;

   stim_row_type directed_rows [0:17] = '{
      // lone sample: empty profile, flag-only result
      '{KEEP, 12'h000, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b1}},
      // two samples: too short for a peak
      '{KEEP, 12'hFFF, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h000, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b1}},
      // full-scale spike: one peak at index 1, mean 1.0
      '{KEEP, 12'h000, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'hFFF, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h000, 1'b1, 1'b1, '{16'd16, 1'b1, 1'b1}},
      // flat run: every inner index is a peak, all merge into one cluster
      '{KEEP, 12'hAAA, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'hAAA, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'hAAA, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'hAAA, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'hAAA, 1'b1, 1'b0, NO_REPORT},
      // zero distance: each peak closes the previous cluster; the last sample
      // both closes one cluster and flushes the next, two results in one transfer
      '{0,    12'h000, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h555, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h000, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h555, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h000, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h555, 1'b0, 1'b0, NO_REPORT},
      '{KEEP, 12'h000, 1'b1, 1'b0, NO_REPORT}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic [SAMPLE_BITS-1:0]          req_sample = '0;
   logic                            req_last_sample = 1'b0;
   logic                            rsp_pop = 1'b0;
   logic                            csr_valid = 1'b0;
   logic [ppc_pkg::DIST_BITS-1:0]   csr_data = '0;
   logic                            req_full;
   logic                            rsp_empty;
   logic [ppc_pkg::POS_BITS-1:0]    rsp_peak_position;
   logic                            rsp_peak_valid;
   logic                            rsp_last_peak;
   logic                            csr_ready;

   // Shadow of the block's profile state and its one register.
   logic [ppc_pkg::DIST_BITS-1:0] merge_distance = ppc_pkg::DIST_RESET;
   logic [INDEX_BITS-1:0]         level_index;
   logic [SAMPLE_BITS-1:0]        prev_level;
   logic signed [SAMPLE_BITS:0]   prev_slope;
   logic                          group_open;
   logic [SAMPLE_BITS-1:0]        group_first;
   logic [SUM_BITS-1:0]           group_sum;
   logic [INDEX_BITS-1:0]         group_count;

   peak_report_type fresh [2];
   int              fresh_n;
   peak_report_type pending_peaks [$];

   gap_mode_type req_mode = GAP_FULL;
   gap_mode_type reply_mode = GAP_FULL;
   logic         hold_replies = 1'b0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           fail_count = 0;

   always #4 clock = ~clock;

   profile_peak_cluster_unit #(
      .MAX_SAMPLES   (MAX_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample        (req_sample),
      .req_last_sample   (req_last_sample),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_peak_position (rsp_peak_position),
      .rsp_peak_valid    (rsp_peak_valid),
      .rsp_last_peak     (rsp_last_peak),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // Drop all profile state back to its reset values; the register is kept.
   task automatic restart_profile();
      level_index = '0;
      prev_level  = '0;
      prev_slope  = '0;
      group_open  = 1'b0;
      group_first = '0;
      group_sum   = '0;
      group_count = '0;
   endtask

   // Mean index of the open cluster, truncated fixed point, saturated to the port width.
   function automatic peak_report_type group_report(input logic is_last);
      logic [SUM_BITS+FRACTION_BITS-1:0] scaled;
      logic [SUM_BITS+FRACTION_BITS-1:0] mean;
      peak_report_type r;
      scaled = {group_sum, {FRACTION_BITS{1'b0}}};
      mean = scaled / group_count;
      r.position = (mean > ppc_pkg::POS_MAX) ? ppc_pkg::POS_MAX : mean[ppc_pkg::POS_BITS-1:0];
      r.valid = 1'b1;
      r.last = is_last;
      return r;
   endfunction

   // Advance the shadow state by one sample and leave its results in fresh[].
   task automatic fold_sample(input logic [SAMPLE_BITS-1:0] level, input logic is_last);
      logic signed [SAMPLE_BITS:0] slope;
      logic [SAMPLE_BITS-1:0]      peak;
      fresh_n = 0;
      // Past the profile limit the sample is ignored; only its last flag counts.
      if (level_index < MAX_SAMPLES) begin
         if (level_index >= 1) begin
            slope = $signed({1'b0, level}) - $signed({1'b0, prev_level});
            // A peak sits one index back: rising or flat into it, falling or flat out of it.
            if (level_index >= 2 && prev_slope >= 0 && slope <= 0) begin
               peak = SAMPLE_BITS'(level_index - 1'b1);
               // Peaks only grow, so the open cluster is the only one that can take it.
               if (group_open && (peak - group_first) < merge_distance) begin
                  group_sum += SUM_BITS'(peak);
                  group_count += 1'b1;
               end else begin
                  if (group_open) begin
                     fresh[fresh_n] = group_report(1'b0);
                     fresh_n++;
                  end
                  group_open  = 1'b1;
                  group_first = peak;
                  group_sum   = SUM_BITS'(peak);
                  group_count = INDEX_BITS'(1);
               end
            end
            prev_slope = slope;
         end
         prev_level = level;
         level_index += 1'b1;
      end
      // Flush after the sample's own work, so a closing cluster comes out first.
      if (is_last) begin
         if (group_open) begin
            fresh[fresh_n] = group_report(1'b1);
         end else begin
            fresh[fresh_n] = '{position: '0, valid: 1'b0, last: 1'b1};
         end
         fresh_n++;
         restart_profile();
      end
   endtask

   function automatic int draw_gap(input gap_mode_type mode);
      case (mode)
         GAP_NONE: return 0;
         GAP_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         default:  return $urandom_range(0, 19);
      endcase
   endfunction

   // Mostly short profiles, a few too short for any peak, a few long ones.
   function automatic int draw_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom_range(1, 2);
      if (pick == 9) return $urandom_range(41, 150);
      return $urandom_range(3, 40);
   endfunction

   // Offer one sample until the block takes it, then record what it must produce.
   // Leave push high on return so back-to-back transfers need no second assignment.
   task automatic offer_sample(input logic [SAMPLE_BITS-1:0] level, input logic is_last,
                               input logic typed, input peak_report_type want);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample <= level;
      req_last_sample <= is_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      fold_sample(level, is_last);
      if (typed) begin
         pending_peaks = {pending_peaks, want};
      end else begin
         for (int k = 0; k < fresh_n; k++) pending_peaks = {pending_peaks, fresh[k]};
      end
      items_sent++;
   endtask

   // Hold the input idle until every expected result has been popped.
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_peaks.size() != 0) @(posedge clock);
   endtask

   // Write the merge distance only with the block drained and the divider at rest.
   task automatic write_distance(input logic [ppc_pkg::DIST_BITS-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      merge_distance = value;
   endtask

   task automatic run_profile(input int len, input shape_type shape);
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] hi;
      logic [SAMPLE_BITS-1:0] lo;
      logic                   rising;
      int                     step;
      int                     half;
      hi = SAMPLE_BITS'($urandom_range(0, 4095));
      lo = SAMPLE_BITS'($urandom_range(0, 4095));
      half = $urandom_range(1, 4);
      level = SAMPLE_BITS'($urandom_range(0, 4095));
      rising = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
         case (shape)
            SHAPE_NOISE: level = SAMPLE_BITS'($urandom_range(0, 4095));
            SHAPE_WALK: begin
               // Drift with occasional turns: broad bumps that cluster at moderate distances.
               if ($urandom_range(0, 7) == 0) rising = !rising;
               step = $urandom_range(0, 300);
               if (rising) begin
                  level = (int'(level) + step > 4095) ? 12'hFFF : 12'(int'(level) + step);
               end else begin
                  level = (int'(level) < step) ? 12'h000 : 12'(int'(level) - step);
               end
            end
            SHAPE_PLATEAU: begin
               // Hold levels so flat stretches turn every inner index into a peak.
               if ($urandom_range(0, 3) == 0) begin
                  case ($urandom_range(0, 2))
                     0:       level = 12'h000;
                     1:       level = 12'hFFF;
                     default: level = SAMPLE_BITS'($urandom_range(0, 4095));
                  endcase
               end
            end
            default: level = (((k / half) % 2) == 0) ? lo : hi;
         endcase
         offer_sample(level, k == len - 1, 1'b0, NO_REPORT);
      end
   endtask

   task automatic run_phase(input int budget);
      int start;
      int len;
      start = items_sent;
      while (items_sent - start < budget) begin
         // Now and then pause the sender until the block has emptied.
         if ($urandom_range(0, 9) == 0) drain_results();
         len = draw_length();
         // Trim the closing profile so the phase ends on its budget.
         if (len > budget - (items_sent - start)) len = budget - (items_sent - start);
         run_profile(len, shape_type'($urandom_range(0, 3)));
      end
   endtask

   task automatic check_report(input peak_report_type got);
      peak_report_type want;
      if (pending_peaks.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d not expected: position %0d valid %0b last %0b",
                     results_seen, got.position, got.valid, got.last);
         end
      end else begin
         want = pending_peaks.pop_front();
         if (got.position !== want.position || got.valid !== want.valid ||
             got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("result %0d: expected position %0d valid %0b last %0b, got %0d %0b %0b",
                        results_seen, want.position, want.valid, want.last,
                        got.position, got.valid, got.last);
            end
         end
      end
      results_seen++;
   endtask

   // Result side: pop after a drawn idle, or after a long hold when asked, and check
   // each transfer against the oldest expectation.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = hold_replies ? HOLD_CYCLES : draw_gap(reply_mode);
         hold_replies = 1'b0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            for (int c = 0; c < gap; c++) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_report({rsp_peak_position, rsp_peak_valid, rsp_last_peak});
      end
   end

   // Stimulus: directed table, random phases over several distances, and a fill-up
   // under a stalled receiver.
   initial begin
      int phase_distance;
      restart_profile();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; the reset distance applies until the first write.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_distance != KEEP) begin
            write_distance(12'(directed_rows[r].set_distance));
         end
         offer_sample(directed_rows[r].sample, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);
      end

      // Cover both distance extremes, near-zero, the reset value and random settings.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       phase_distance = 4095;
            1:       phase_distance = 1;
            2:       phase_distance = 0;
            3:       phase_distance = int'(ppc_pkg::DIST_RESET);
            4:       phase_distance = 7;
            default: phase_distance = $urandom_range(2, 4094);
         endcase
         write_distance(12'(phase_distance));
         req_mode = gap_mode_type'($urandom_range(0, 2));
         reply_mode = gap_mode_type'($urandom_range(0, 2));
         run_phase(RANDOM_ITEMS / RANDOM_PHASES);
      end

      // Stall the receiver while every peak closes a cluster: fill the job queue
      // until the input backs up.
      write_distance(12'd0);
      req_mode = GAP_NONE;
      reply_mode = GAP_SOME;
      hold_replies = 1'b1;
      run_profile(80, SHAPE_ZIGZAG);

      // Wait out the tail so a stray extra result still gets caught.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/ppc_pkg.sv
rtl/core/ppc_queue.sv
rtl/core/ppc_front.sv
rtl/core/ppc_back.sv
rtl/core/profile_peak_cluster_unit.sv
sim/profile_peak_cluster_unit_test.sv
